// ===== rtl/tiled_texture_format_decoder_core_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef TILED_TEXTURE_FORMAT_DECODER_CORE_MACROS_SVH
`define TILED_TEXTURE_FORMAT_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/ttfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Tiled texture decoder package
// Format codes, register indexes and small color helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ttfd_pkg;

    typedef logic [2:0] fmt_t;

    localparam fmt_t FMT_I4     = 3'd0;
    localparam fmt_t FMT_I8     = 3'd1;
    localparam fmt_t FMT_IA4    = 3'd2;
    localparam fmt_t FMT_IA8    = 3'd3;
    localparam fmt_t FMT_RGB565 = 3'd4;
    localparam fmt_t FMT_RGB5A3 = 3'd5;
    localparam fmt_t FMT_RGBA8  = 3'd6;
    localparam fmt_t FMT_CMPR   = 3'd7;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef logic [7:0] chan_t;

    function automatic chan_t div3(input chan_t v);
        logic [16:0] prod;
        prod = 17'(v) * 17'd171;
        return prod[16:9];
    endfunction

    function automatic chan_t nib_expand(input logic [3:0] n);
        return {n, n};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tiled_texture_format_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Tiled texture format decoder core
// Expands tiled encoded texture words into RGBA8 pixels with coordinates.
// ----------------------------------------------------------------------------
// The input stream carries one 64-bit encoded word per request, in tile order,
// first byte in bits 63 to 56. The output stream carries one decoded pixel per
// request, with tlast on the final pixel of each input word. The user must set
// format and image size through the APB port only while the block is idle; the
// block itself does not enforce this. A word is taken into a holding register
// and its pixels leave one per cycle through the output register while the
// receiver takes them. A word has 16 pixels for I4 and CMPR, 8 for I8 and IA4,
// 4 for the 16-bit formats and RGBA8 green/blue words; RGBA8 alpha/red words
// produce no pixels. Each pixel passes through the holding register and then
// the output register. The next word is accepted in the cycle that the last
// pixel of the held word moves to the output register. When the receiver
// stalls, the output register holds and the holding register waits, so nothing
// is lost. Reset clears the tile counters and both valid flags and resets the
// configuration; the RGBA8 alpha/red store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tiled_texture_format_decoder_core_macros.svh"

module tiled_texture_format_decoder_core #(
    parameter int MAX_SIDE = 1024,
    parameter int CW       = $clog2(MAX_SIDE),
    parameter int TDATA_W  = ((2 * CW + 32 + 7) / 8) * 8
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [63:0]         s_tdata,   // encoded_word
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // pixel_x, pixel_y, red, green, blue, alpha
    output logic                m_tlast,   // last_of_word
    output logic [1:0]          m_tuser,   // inside_image, image_end
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ttfd_pkg::*;

    localparam int SW = (CW + 2 > 11) ? CW + 2 : 11;

    fmt_t        fmt_reg;
    logic [10:0] width_reg, height_reg;
    logic [CW-1:0] ox_reg, oy_reg;
    logic [2:0]  wit_reg;
    logic [63:0] store_reg [4];

    logic          hold_valid_reg;
    logic [63:0]   hword_reg;
    fmt_t          hfmt_reg;
    logic [CW-1:0] hox_reg, hoy_reg;
    logic [2:0]    hw_reg;
    logic [4:0]    hn_reg;
    logic          hend_reg;
    logic [3:0]    cnt_reg;

    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;
    logic [1:0]         m_tuser_reg;

    logic [SW-1:0] wdt, hgt, nw, nh, bw, bh;
    logic [2:0]    wpt_m1, w_cur;
    logic          final_word, row_end, col_end, s_acc, cfg_wr;
    logic [4:0]    n_cur;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT: prdata = {29'd0, fmt_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {21'd0, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (width_reg == 11'd0) begin
            wdt = SW'(1);
        end else if (SW'(width_reg) > SW'(MAX_SIDE)) begin
            wdt = SW'(MAX_SIDE);
        end else begin
            wdt = SW'(width_reg);
        end
        if (height_reg == 11'd0) begin
            hgt = SW'(1);
        end else if (SW'(height_reg) > SW'(MAX_SIDE)) begin
            hgt = SW'(MAX_SIDE);
        end else begin
            hgt = SW'(height_reg);
        end
        bw = (fmt_reg inside {FMT_I4, FMT_I8, FMT_IA4, FMT_CMPR}) ? SW'(8) : SW'(4);
        bh = (fmt_reg inside {FMT_I4, FMT_CMPR}) ? SW'(8) : SW'(4);
        wpt_m1 = (fmt_reg == FMT_RGBA8) ? 3'd7 : 3'd3;
        nw = (wdt + bw - SW'(1)) & ~(bw - SW'(1));
        nh = (hgt + bh - SW'(1)) & ~(bh - SW'(1));
        final_word = wit_reg >= wpt_m1;
        w_cur = final_word ? wpt_m1 : wit_reg;
        row_end = (SW'(ox_reg) + bw) >= nw;
        col_end = (SW'(oy_reg) + bh) >= nh;
        case (fmt_reg)
            FMT_I4, FMT_CMPR: n_cur = 5'd16;
            FMT_I8, FMT_IA4:  n_cur = 5'd8;
            FMT_RGBA8:        n_cur = (w_cur < 3'd4) ? 5'd0 : 5'd4;
            default:          n_cur = 5'd4;
        endcase
    end

    logic out_free, adv, pix_last, done;
    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = hold_valid_reg && (hn_reg != 5'd0) && out_free;
    assign pix_last = {1'b0, cnt_reg} == (hn_reg - 5'd1);
    assign done     = hold_valid_reg && ((hn_reg == 5'd0) || (adv && pix_last));
    assign s_tready = !hold_valid_reg || done;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= FMT_I4;
            width_reg  <= 11'd1;
            height_reg <= 11'd1;
            ox_reg     <= '0;
            oy_reg     <= '0;
            wit_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_FORMAT: fmt_reg    <= pwdata[2:0];
                    REG_WIDTH:  width_reg  <= pwdata[10:0];
                    REG_HEIGHT: height_reg <= pwdata[10:0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                if (final_word) begin
                    wit_reg <= '0;
                    if (row_end) begin
                        ox_reg <= '0;
                        oy_reg <= col_end ? '0 : CW'(SW'(oy_reg) + bh);
                    end else begin
                        ox_reg <= CW'(SW'(ox_reg) + bw);
                    end
                end else begin
                    wit_reg <= wit_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && (fmt_reg == FMT_RGBA8) && (w_cur < 3'd4)) begin
            store_reg[w_cur[1:0]] <= s_tdata;
        end
        if (s_acc) begin
            hword_reg <= s_tdata;
            hfmt_reg  <= fmt_reg;
            hox_reg   <= ox_reg;
            hoy_reg   <= oy_reg;
            hw_reg    <= w_cur;
            hn_reg    <= n_cur;
            hend_reg  <= final_word && row_end && col_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            if (s_acc) begin
                hold_valid_reg <= 1'b1;
                cnt_reg        <= '0;
            end else begin
                if (done) begin
                    hold_valid_reg <= 1'b0;
                end
                if (adv) begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
        end
    end

    logic [3:0]  dx, dy;
    chan_t       byt, rr, gg, bb, aa;
    logic [15:0] hv, ar, c0, c1;
    logic [1:0]  idx;
    chan_t       p0 [4];
    chan_t       p1 [4];
    chan_t       pc [4];
    logic [SW-1:0] xf, yf;

    always_comb begin
        byt = hword_reg[8 * (7 - int'(hfmt_reg == FMT_I4 ? {1'b0, cnt_reg[3:1]}
                                                         : {1'b0, cnt_reg[2:0]})) +: 8];
        hv  = hword_reg[16 * (3 - int'(cnt_reg[1:0])) +: 16];
        ar  = store_reg[hw_reg[1:0]][16 * (3 - int'(cnt_reg[1:0])) +: 16];
        c0  = hword_reg[63:48];
        c1  = hword_reg[47:32];
        idx = hword_reg[2 * (15 - int'(cnt_reg)) +: 2];
        p0[0] = {c0[15:11], 3'b0};
        p0[1] = {c0[10:5], 2'b0};
        p0[2] = {c0[4:0], 3'b0};
        p0[3] = 8'hFF;
        p1[0] = {c1[15:11], 3'b0};
        p1[1] = {c1[10:5], 2'b0};
        p1[2] = {c1[4:0], 3'b0};
        p1[3] = 8'hFF;
        for (int ch = 0; ch < 4; ch++) begin
            case (idx)
                2'd0: pc[ch] = p0[ch];
                2'd1: pc[ch] = p1[ch];
                2'd2: pc[ch] = (c0 < c1) ? chan_t'((p0[ch] >> 1) + (p1[ch] >> 1))
                                         : chan_t'(div3(p1[ch]) + (div3(p0[ch]) << 1));
                default: pc[ch] = (c0 < c1) ? 8'd0
                                            : chan_t'(div3(p0[ch]) + (div3(p1[ch]) << 1));
            endcase
        end
        dx = {2'b0, cnt_reg[1:0]};
        dy = {1'b0, hw_reg};
        rr = 8'd0;
        gg = 8'd0;
        bb = 8'd0;
        aa = 8'hFF;
        case (hfmt_reg)
            FMT_I4: begin
                dx = {1'b0, cnt_reg[2:0]};
                dy = {hw_reg, 1'b0} + {3'b0, cnt_reg[3]};
                rr = nib_expand(cnt_reg[0] ? byt[3:0] : byt[7:4]);
                gg = rr;
                bb = rr;
            end
            FMT_I8: begin
                dx = {1'b0, cnt_reg[2:0]};
                rr = byt;
                gg = byt;
                bb = byt;
            end
            FMT_IA4: begin
                dx = {1'b0, cnt_reg[2:0]};
                rr = nib_expand(byt[3:0]);
                gg = rr;
                bb = rr;
                aa = nib_expand(byt[7:4]);
            end
            FMT_IA8: begin
                rr = hv[7:0];
                gg = hv[7:0];
                bb = hv[7:0];
                aa = hv[15:8];
            end
            FMT_RGB565: begin
                rr = {hv[15:11], 3'b0};
                gg = {hv[10:5], 2'b0};
                bb = {hv[4:0], 3'b0};
            end
            FMT_RGB5A3: begin
                if (hv[15]) begin
                    rr = {hv[14:10], 3'b0};
                    gg = {hv[9:5], 3'b0};
                    bb = {hv[4:0], 3'b0};
                end else begin
                    rr = nib_expand(hv[11:8]);
                    gg = nib_expand(hv[7:4]);
                    bb = nib_expand(hv[3:0]);
                    aa = {hv[14:12], 5'b0};
                end
            end
            FMT_RGBA8: begin
                dy = {2'b0, hw_reg[1:0]};
                rr = ar[7:0];
                gg = hv[15:8];
                bb = hv[7:0];
                aa = ar[15:8];
            end
            default: begin
                dx = {1'b0, hw_reg[0], cnt_reg[1:0]};
                dy = {1'b0, hw_reg[1], cnt_reg[3:2]};
                rr = pc[0];
                gg = pc[1];
                bb = pc[2];
                aa = pc[3];
            end
        endcase
        xf = SW'(hox_reg) + SW'(dx);
        yf = SW'(hoy_reg) + SW'(dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= TDATA_W'({aa, bb, gg, rr, yf[CW-1:0], xf[CW-1:0]});
            m_tlast_reg <= pix_last;
            m_tuser_reg <= {pix_last && hend_reg, (xf < wdt) && (yf < hgt)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `TTFD_ASSERT_NEXT(a_hold_loads, aclk, aresetn, s_acc, hold_valid_reg)
    `TTFD_ASSERT_NOW(a_cnt_range, aclk, aresetn, hold_valid_reg && (hn_reg != 5'd0), {1'b0, cnt_reg} < hn_reg)
    `TTFD_ASSERT_NOW(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast)
    `TTFD_ASSERT_NEXT(a_pixel_moves, aclk, aresetn, adv, m_tvalid)

endmodule

`default_nettype wire
